/* sv/tzcl_pkg.sv */
// Shared types, constants and helpers for the thermal zone current limit block.
`default_nettype none

package tzcl_pkg;

    localparam int ZONE_BITS     = 4;
    localparam int ZONES         = 1 << ZONE_BITS;
    localparam int CNT_BITS      = ZONE_BITS + 1;
    localparam int CUR_BITS      = 16;
    localparam int DEPTH_DEF     = 16;
    localparam int TEMP_BITS_DEF = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Result of one temperature sample.
    typedef struct packed {
        logic                 capped;
        logic [ZONE_BITS-1:0] zone;
        logic [CUR_BITS-1:0]  current;
    } res_t;

    // Zone index at or above the count falls back to the last valid zone.
    function automatic logic [ZONE_BITS-1:0] clamp_zone(
        input logic [ZONE_BITS-1:0] z,
        input logic [CNT_BITS-1:0]  n
    );
        logic [CNT_BITS-1:0] n_m1;
        begin
            n_m1 = n - CNT_BITS'(1);
            return ({1'b0, z} >= n) ? n_m1[ZONE_BITS-1:0] : z;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/thermal_zone_current_limit_top.sv */
// Top level of the thermal zone current limit block: stream ports, register, output stage.
`default_nettype none

// Thermal zone current limit. Each transfer on the s_ group is either a zone
// table write (s_tuser = 1), which loads one entry and forces the next sample
// to search the table afresh, or a temperature sample (s_tuser = 0), which
// yields exactly one result on the m_ group: the current limit and index of
// the zone in force and a flag set when the walk stopped at the DEPTH step cap.
// entry_count is written over cfg_valid/cfg_ready/cfg_data; the user must
// write it only while the block is idle, which the block does not enforce;
// 0 acts as 1 and values above 16 as 16. All table reads go through the
// single read port of the zone memory, one entry per cycle. The first sample
// after reset or a write scans from entry 0 to the first that fits, or the
// last; a later sample walks at most DEPTH link steps. The result register
// lets the next item in while a result waits on m_tready. The table has no
// reset; reading an entry never written gives undefined fields.
module thermal_zone_current_limit_top #(
    parameter int DEPTH     = tzcl_pkg::DEPTH_DEF,
    parameter int TEMP_BITS = tzcl_pkg::TEMP_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: entry_count
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tzcl_pkg::CNT_BITS-1:0] cfg_data,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // from bit 0: temperature, entry_index, cool_threshold, heat_threshold,
    // zone_current, heat_link, cool_link, zero fill
    input  wire logic [((3*TEMP_BITS+28+7)/8)*8-1:0] s_tdata,
    // operation
    input  wire logic                          s_tuser,
    // results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // from bit 0: current_limit, zone_index, walk_capped, zero fill
    output logic [23:0]                        m_tdata
);

    localparam int TB = TEMP_BITS;
    localparam int EW = 2 * TEMP_BITS + 24;   // stored entry width
    localparam int CB = tzcl_pkg::CNT_BITS;

    logic [CB-1:0] entry_count_reg;
    logic [CB-1:0] n;

    logic                  m_tvalid_reg, m_tvalid_next;
    tzcl_pkg::res_t        m_res_reg;

    logic                  res_valid, res_ready;
    tzcl_pkg::res_t        res;

    logic                  mem_we;
    logic [tzcl_pkg::ZONE_BITS-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0]         mem_wdata, mem_rdata;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CB'(1);
        end
        else if (cfg_valid)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // usable zone count, 1 .. ZONES
    always_comb
    begin
        priority if (entry_count_reg == '0)
        begin
            n = CB'(1);
        end
        else if (entry_count_reg > CB'(tzcl_pkg::ZONES))
        begin
            n = CB'(tzcl_pkg::ZONES);
        end
        else
        begin
            n = entry_count_reg;
        end
    end

    tzcl_walk_ctrl #(
        .DEPTH     (DEPTH),
        .TEMP_BITS (TEMP_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_temp   (s_tdata[TB-1:0]),
        .in_idx    (s_tdata[TB+3:TB]),
        .in_cool   (s_tdata[2*TB+3:TB+4]),
        .in_heat   (s_tdata[3*TB+3:2*TB+4]),
        .in_cur    (s_tdata[3*TB+19:3*TB+4]),
        .in_hl     (s_tdata[3*TB+23:3*TB+20]),
        .in_cl     (s_tdata[3*TB+27:3*TB+24]),
        .n         (n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tzcl_zone_mem #(
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: takes a result whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_res_reg.capped, m_res_reg.zone, m_res_reg.current};

endmodule

`default_nettype wire

/* sv/tzcl_zone_mem.sv */
// Zone table: one write port, one read port, registered read data.
`default_nettype none

module tzcl_zone_mem #(
    parameter int WIDTH = 2 * tzcl_pkg::TEMP_BITS_DEF + 24
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [tzcl_pkg::ZONE_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]               wdata,
    input  wire logic [tzcl_pkg::ZONE_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem [tzcl_pkg::ZONES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/tzcl_walk_ctrl.sv */
// Sequencer: table writes, first-sample zone search and the link walk.
`default_nettype none

module tzcl_walk_ctrl #(
    parameter int DEPTH     = tzcl_pkg::DEPTH_DEF,
    parameter int TEMP_BITS = tzcl_pkg::TEMP_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // item side
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_op,
    input  wire logic signed [TEMP_BITS-1:0]    in_temp,
    input  wire logic [tzcl_pkg::ZONE_BITS-1:0] in_idx,
    input  wire logic signed [TEMP_BITS-1:0]    in_cool,
    input  wire logic signed [TEMP_BITS-1:0]    in_heat,
    input  wire logic [tzcl_pkg::CUR_BITS-1:0]  in_cur,
    input  wire logic [tzcl_pkg::ZONE_BITS-1:0] in_hl,
    input  wire logic [tzcl_pkg::ZONE_BITS-1:0] in_cl,
    input  wire logic [tzcl_pkg::CNT_BITS-1:0]  n,
    // result side
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output tzcl_pkg::res_t                      res,
    // table port
    output logic                                mem_we,
    output logic [tzcl_pkg::ZONE_BITS-1:0]      mem_waddr,
    output logic [2*TEMP_BITS+23:0]             mem_wdata,
    output logic [tzcl_pkg::ZONE_BITS-1:0]      mem_raddr,
    input  wire logic [2*TEMP_BITS+23:0]        mem_rdata
);

    localparam int ZB = tzcl_pkg::ZONE_BITS;
    localparam int SW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MAX, S_MIN, S_WALK, S_DONE} state_t;
    typedef enum logic [1:0] {K_NONE, K_HEAT, K_COOL} kind_t;

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [ZB-1:0]         scan_reg, scan_next;
    logic [ZB-1:0]         z_reg, z_next;
    logic [ZB-1:0]         zone_reg, zone_next;
    logic [SW-1:0]         steps_reg, steps_next;
    logic                  located_reg, located_next;
    logic signed [TEMP_BITS-1:0] t_reg, t_next;
    logic signed [TEMP_BITS-1:0] tracked_reg, tracked_next;
    logic signed [TEMP_BITS-1:0] tmax_reg, tmax_next;
    logic signed [TEMP_BITS-1:0] tmin_reg, tmin_next;
    tzcl_pkg::res_t        res_reg, res_next;

    // entry fields as read back
    logic signed [TEMP_BITS-1:0] e_cool, e_heat, r_eff;
    logic [tzcl_pkg::CUR_BITS-1:0] e_cur;
    logic [ZB-1:0]         e_hl, e_cl, z_heat, z_cool, z_start;
    logic [tzcl_pkg::CNT_BITS-1:0] n_m1;

    assign e_cool = mem_rdata[TEMP_BITS-1:0];
    assign e_heat = mem_rdata[2*TEMP_BITS-1:TEMP_BITS];
    assign e_cur  = mem_rdata[2*TEMP_BITS+15:2*TEMP_BITS];
    assign e_hl   = mem_rdata[2*TEMP_BITS+19:2*TEMP_BITS+16];
    assign e_cl   = mem_rdata[2*TEMP_BITS+23:2*TEMP_BITS+20];

    assign n_m1    = n - tzcl_pkg::CNT_BITS'(1);
    assign z_heat  = tzcl_pkg::clamp_zone(e_hl, n);
    assign z_cool  = tzcl_pkg::clamp_zone(e_cl, n);
    assign z_start = tzcl_pkg::clamp_zone(zone_reg, n);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign mem_waddr = in_idx;
    assign mem_wdata = {in_cl, in_hl, in_cur, in_heat, in_cool};

    // tracked temperature after the step that brought in the entry now on the read port
    always_comb
    begin
        unique case (kind_reg)
            K_HEAT:
                r_eff = (t_reg > e_heat && e_heat < tmax_reg) ? e_heat : t_reg;
            K_COOL:
                r_eff = (t_reg <= e_cool && e_cool > tmin_reg) ? e_heat : t_reg;
            default:
                r_eff = tracked_reg;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        scan_next    = scan_reg;
        z_next       = z_reg;
        zone_next    = zone_reg;
        steps_next   = steps_reg;
        located_next = located_reg;
        t_next       = t_reg;
        tracked_next = tracked_reg;
        tmax_next    = tmax_reg;
        tmin_next    = tmin_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_raddr    = z_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == tzcl_pkg::OP_WRITE)
                    begin
                        mem_we       = 1'b1;
                        located_next = 1'b0;
                    end
                    else
                    begin
                        t_next = in_temp;
                        if (!located_reg)
                        begin
                            mem_raddr  = '0;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            mem_raddr  = n_m1[ZB-1:0];
                            state_next = S_MAX;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (t_reg <= e_heat || scan_reg == n_m1[ZB-1:0])
                begin
                    res_next.current = e_cur;
                    res_next.zone    = scan_reg;
                    res_next.capped  = 1'b0;
                    zone_next        = scan_reg;
                    tracked_next     = t_reg;
                    located_next     = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + ZB'(1);
                    mem_raddr = scan_reg + ZB'(1);
                end
            end

            S_MAX:
            begin
                tmax_next  = e_heat;
                mem_raddr  = '0;
                state_next = S_MIN;
            end

            S_MIN:
            begin
                tmin_next  = e_cool;
                z_next     = z_start;
                mem_raddr  = z_start;
                kind_next  = K_NONE;
                steps_next = '0;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                res_next.current = e_cur;
                res_next.zone    = z_reg;
                res_next.capped  = 1'b0;
                priority if (t_reg == r_eff)
                begin
                    tracked_next = r_eff;
                    zone_next    = z_reg;
                    state_next   = S_DONE;
                end
                else if (steps_reg >= SW'(DEPTH))
                begin
                    res_next.capped = 1'b1;
                    tracked_next    = r_eff;
                    zone_next       = z_reg;
                    state_next      = S_DONE;
                end
                else if (t_reg > r_eff && t_reg > e_heat)
                begin
                    tracked_next = r_eff;
                    z_next       = z_heat;
                    mem_raddr    = z_heat;
                    kind_next    = K_HEAT;
                    steps_next   = steps_reg + SW'(1);
                end
                else if (t_reg < r_eff && t_reg <= e_cool)
                begin
                    tracked_next = r_eff;
                    z_next       = z_cool;
                    mem_raddr    = z_cool;
                    kind_next    = K_COOL;
                    steps_next   = steps_reg + SW'(1);
                end
                else
                begin
                    // thresholds hold: settle on the sample
                    tracked_next = t_reg;
                    zone_next    = z_reg;
                    state_next   = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            kind_reg    <= K_NONE;
            steps_reg   <= '0;
            located_reg <= 1'b0;
            zone_reg    <= '0;
            tracked_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            steps_reg   <= steps_next;
            located_reg <= located_next;
            zone_reg    <= zone_next;
            tracked_reg <= tracked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        z_reg    <= z_next;
        t_reg    <= t_next;
        tmax_reg <= tmax_next;
        tmin_reg <= tmin_next;
        res_reg  <= res_next;
    end

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= SW'(DEPTH))
        else $error("walk step count past cap");

    a_write_clears_located: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == tzcl_pkg::OP_WRITE) |=> !located_reg)
        else $error("table write left located set");

    a_sample_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == tzcl_pkg::OP_SAMPLE) |=> !in_ready)
        else $error("new item taken while a sample is in progress");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire
